// ===== sv/mvsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_pkg: shared constants and functions
// Command codes, status codes, defaults and the sine behind the equal-power pan table.
// ----------------------------------------------------------------------------
package mvsm_pkg;

    localparam int DEF_VOICES            = 64;
    localparam int DEF_SAMPLE_FRAMES     = 65536;
    localparam int DEF_GEN_BITS          = 8;
    localparam int DEF_PAN_TABLE_ENTRIES = 256;

    localparam logic [3:0] CMD_TICK   = 4'd0;
    localparam logic [3:0] CMD_START  = 4'd1;
    localparam logic [3:0] CMD_STOP   = 4'd2;
    localparam logic [3:0] CMD_GAIN   = 4'd3;
    localparam logic [3:0] CMD_PAN    = 4'd4;
    localparam logic [3:0] CMD_SEEK   = 4'd5;
    localparam logic [3:0] CMD_PAUSE  = 4'd6;
    localparam logic [3:0] CMD_RESUME = 4'd7;
    localparam logic [3:0] CMD_MASTER = 4'd8;
    localparam logic [3:0] CMD_LOAD   = 4'd9;
    localparam logic [3:0] CMD_QUERY  = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STALE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [15:0] UNITY = 16'd32768;

    // sin(k/n * pi/2) in Q1.15, fixed-point Taylor series to x^11
    function automatic logic [15:0] pan_sine(input int k, input int n);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(k) * 64'd1686629713) / 64'(n);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int i = 1; i <= 5; i++) begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) sum = (term < sum) ? sum - term : 64'd0;
            else            sum = sum + term;
        end
        r = (sum + 64'd16384) >> 15;
        return (r > 64'd32768) ? UNITY : r[15:0];
    endfunction

endpackage

// ===== sv/mvsm_voice_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_voice_ram: per-voice parameter memory
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module mvsm_voice_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 66
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/multi_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer: voice-pool sample playback mixer
// Control commands pass through voice read, command and output states;
// a start first picks the lowest free slot, and a full pool skips to output.
// A tick walks every voice in turn through the mix walk: voice-memory read,
// pan and voice gain, master scale, accumulate.
// One item at a time; the next beat is taken only once the result is accepted.
// Reset: i_rst_n clears flags, valid bits and master level in flip-flops;
// voice entries read as reset values until first written; samples not cleared.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer
    import mvsm_pkg::*;
#(
    parameter int VOICES            = DEF_VOICES,
    parameter int SAMPLE_FRAMES     = DEF_SAMPLE_FRAMES,
    parameter int GEN_BITS          = DEF_GEN_BITS,
    parameter int PAN_TABLE_ENTRIES = DEF_PAN_TABLE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_command,
    input  logic [5:0]         i_slot,
    input  logic [7:0]         i_generation,
    input  logic [15:0]        i_address,
    input  logic [16:0]        i_frame_length,
    input  logic [15:0]        i_level,
    input  logic signed [15:0] i_pan,
    input  logic               i_loop_enable,
    input  logic [15:0]        i_seek_fraction,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [5:0]         o_handle_slot,
    output logic [7:0]         o_handle_generation,
    output logic signed [15:0] o_left_out,
    output logic signed [15:0] o_right_out,
    output logic               o_voice_active,
    output logic               o_voice_paused,
    output logic [16:0]        o_voice_position
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = $clog2(SAMPLE_FRAMES);
    localparam int PW = $clog2(PAN_TABLE_ENTRIES);
    // voice word: gen | base16 | len17 | pos17 | gain16 | pan16
    localparam int RW = GEN_BITS + 16 + 17 + 17 + 32;

    typedef struct packed {
        logic [GEN_BITS-1:0] gen;
        logic [15:0]         base;
        logic [16:0]         len;
        logic [16:0]         pos;
        logic [15:0]         gain;
        logic [15:0]         pan;
    } t_voice;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_SCAN  = 9'b0_0000_0010,
        S_RD    = 9'b0_0000_0100,
        S_CMD   = 9'b0_0000_1000,
        S_TRD   = 9'b0_0001_0000,
        S_TMIX  = 9'b0_0010_0000,
        S_TMUL  = 9'b0_0100_0000,
        S_OUT   = 9'b0_1000_0000,
        S_TACC  = 9'b1_0000_0000
    } t_state;

    // quarter-wave sine table, built at elaboration
    typedef logic [PAN_TABLE_ENTRIES:0][15:0] t_pan_lut;

    function automatic t_pan_lut build_pan_lut();
        t_pan_lut t;
        for (int k = 0; k <= PAN_TABLE_ENTRIES; k++)
            t[k] = pan_sine(k, PAN_TABLE_ENTRIES);
        return t;
    endfunction

    localparam t_pan_lut PAN_LUT = build_pan_lut();

    function automatic logic [15:0] pan_gain(input logic [PW:0] k);
        return PAN_LUT[k];
    endfunction

    // flags kept in flip-flops so reset clears them; valid bit marks a written entry
    logic [VOICES-1:0] r_act, r_pau, r_loop, r_vld;
    logic [15:0]       r_master;
    t_state            r_state;
    logic [VW-1:0]     r_idx;
    logic              r_last;

    // latched input item
    logic [3:0]  r_cmd;
    logic [5:0]  r_slot;
    logic [7:0]  r_gen;
    logic [15:0] r_addr, r_level, r_pan, r_frac;
    logic [16:0] r_flen;
    logic        r_lp;
    logic [15:0] r_left, r_right;

    // output register
    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [5:0]  r_hslot;
    logic [7:0]  r_hgen;
    logic [15:0] r_lout, r_rout;
    logic        r_qact, r_qpau;
    logic [16:0] r_qpos;

    logic signed [47:0] r_accl, r_accr;

    // voice memory
    logic          ram_we;
    logic [VW-1:0] ram_waddr, ram_raddr;
    t_voice        ram_wdata, ram_rdata, cur;

    mvsm_voice_ram #(.DEPTH(VOICES), .WIDTH(RW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // sample memory: write at load, read one word per mixed voice
    logic [31:0] r_smem [SAMPLE_FRAMES];
    logic [31:0] r_sword;
    logic [SW-1:0] smem_raddr;
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMD && r_cmd == CMD_LOAD)
            r_smem[r_addr[SW-1:0]] <= {r_right, r_left};
        r_sword <= r_smem[smem_raddr];
    end

    // entry as read, with reset defaults for entries never written
    logic r_rdvld;
    always_comb begin
        if (r_rdvld) cur = ram_rdata;
        else begin
            cur      = '0;
            cur.gen  = GEN_BITS'(1);
            cur.gain = UNITY;
        end
    end

    // tick per-voice gain pipeline
    logic [PW:0]  pidx;
    logic [15:0]  pgr, pgl;
    logic [31:0]  n_gr1, n_gl1;
    logic [16:0]  r_gr, r_gl, r_gr2, r_gl2;
    logic         r_play, r_play2;
    logic [31:0]  r_sw2;
    logic [16:0]  posfix;
    logic         endreg;
    logic [33:0]  gr_m, gl_m;
    logic [16:0]  seek_pos;

    assign pidx  = (PW+1)'((32'({~cur.pan[15], cur.pan[14:0]}) * PAN_TABLE_ENTRIES) >> 16);
    assign pgr   = pan_gain(pidx);
    assign pgl   = pan_gain((PW+1)'(PAN_TABLE_ENTRIES) - pidx);
    assign n_gr1 = pgr * cur.gain;
    assign n_gl1 = pgl * cur.gain;
    assign endreg = (cur.pos >= cur.len);
    assign posfix = endreg ? 17'd0 : cur.pos;
    assign smem_raddr = SW'({16'd0, cur.base} + 32'(posfix));
    assign gr_m = r_gr * r_master;
    assign gl_m = r_gl * r_master;
    assign seek_pos = 17'((34'(r_frac) * 34'(cur.len)) >> 16);

    logic [VW-1:0] n_free;
    logic          n_found;
    always_comb begin
        n_found = 1'b0;
        n_free  = '0;
        for (int v = VOICES - 1; v >= 0; v--)
            if (!r_act[v]) begin
                n_found = 1'b1;
                n_free  = VW'(v);
            end
    end

    logic match;
    assign match = (32'(r_slot) < VOICES) && (8'(cur.gen) == r_gen);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    function automatic logic signed [15:0] rsat(input logic signed [47:0] a);
        logic signed [47:0] q;
        q = (a + 48'sd16384) >>> 15;
        if (q > 48'sd32767) return 16'sh7fff;
        if (q < -48'sd32768) return 16'sh8000;
        return q[15:0];
    endfunction

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_slot[VW-1:0];
        ram_wdata = cur;
        ram_raddr = r_idx;
        if (r_state == S_IDLE) ram_raddr = i_slot[VW-1:0];
        // a start reads the claimed slot, other commands the handle's slot
        if (r_state == S_RD && r_cmd != CMD_START) ram_raddr = r_slot[VW-1:0];
        if (r_state == S_CMD && match && r_cmd != CMD_QUERY) begin
            ram_we = (r_cmd == CMD_GAIN || r_cmd == CMD_PAN || r_cmd == CMD_SEEK);
            unique case (r_cmd)
                CMD_GAIN: ram_wdata.gain = r_level;
                CMD_PAN:  ram_wdata.pan  = r_pan;
                CMD_SEEK: ram_wdata.pos  = seek_pos;
                default:  ram_wdata      = cur;
            endcase
        end
        if (r_state == S_CMD && r_cmd == CMD_START) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx;
            ram_wdata = '{gen: cur.gen + GEN_BITS'(1), base: r_addr, len: r_flen,
                          pos: 17'd0, gain: r_level, pan: r_pan};
        end
        if (r_state == S_TMIX) begin
            ram_waddr = r_idx;
            ram_wdata = cur;
            ram_wdata.pos = posfix + 17'd1;
            ram_we = r_act[r_idx] && !r_pau[r_idx] && (!endreg || r_loop[r_idx]);
            if (endreg && r_loop[r_idx] && cur.len == 17'd0) ram_wdata.pos = 17'd0;
        end
    end

    // play when the position is inside the region, after a loop wraps to zero
    logic mix_on;
    assign mix_on = r_act[r_idx] && !r_pau[r_idx] &&
                    (!endreg || (r_loop[r_idx] && cur.len != 17'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_act    <= '0;
            r_pau    <= '0;
            r_loop   <= '0;
            r_vld    <= '0;
            r_master <= UNITY;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_rdvld  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_rdvld <= r_vld[i_slot[VW-1:0]];
                    if (i_valid && o_ready) begin
                        r_cmd <= i_command; r_slot <= i_slot; r_gen <= i_generation;
                        r_addr <= i_address; r_flen <= i_frame_length;
                        r_level <= i_level; r_pan <= i_pan; r_lp <= i_loop_enable;
                        r_frac <= i_seek_fraction;
                        r_left <= i_left_sample; r_right <= i_right_sample;
                        r_status <= ST_OK; r_hslot <= '0; r_hgen <= '0;
                        r_lout <= '0; r_rout <= '0;
                        r_qact <= 1'b0; r_qpau <= 1'b0; r_qpos <= '0;
                        r_accl <= '0; r_accr <= '0;
                        r_idx <= '0;
                        if (i_command == CMD_TICK) r_state <= S_TRD;
                        else if (i_command == CMD_START) r_state <= S_SCAN;
                        else r_state <= S_RD;
                    end
                end
                S_SCAN: begin
                    // find the lowest free slot and read it, or report the pool full
                    if (!n_found) begin
                        r_status <= ST_FULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_idx  <= n_free;
                        r_slot <= 6'(n_free);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rdvld <= r_vld[(r_cmd == CMD_START) ? r_idx : r_slot[VW-1:0]];
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    r_state <= S_OUT;
                    priority if (r_cmd == CMD_START) begin
                        r_vld[r_idx]  <= 1'b1;
                        r_act[r_idx]  <= 1'b1;
                        r_pau[r_idx]  <= 1'b0;
                        r_loop[r_idx] <= r_lp;
                        r_hslot <= 6'(r_idx);
                        r_hgen  <= 8'(cur.gen + GEN_BITS'(1));
                    end else if (r_cmd == CMD_MASTER) begin
                        r_master <= (r_level > UNITY) ? UNITY : r_level;
                    end else if (r_cmd == CMD_LOAD || r_cmd > CMD_QUERY) begin
                        r_status <= ST_OK;
                    end else if (r_cmd == CMD_QUERY) begin
                        r_hslot <= r_slot;
                        if (32'(r_slot) < VOICES) r_hgen <= 8'(cur.gen);
                        if (!match) r_status <= ST_STALE;
                        else begin
                            r_qact <= r_act[r_slot[VW-1:0]];
                            r_qpau <= r_pau[r_slot[VW-1:0]];
                            r_qpos <= cur.pos;
                        end
                    end else if (!match) begin
                        r_status <= ST_STALE;
                    end else begin
                        if (ram_we) r_vld[r_slot[VW-1:0]] <= 1'b1;
                        if (r_cmd == CMD_STOP)   r_act[r_slot[VW-1:0]] <= 1'b0;
                        if (r_cmd == CMD_PAUSE)  r_pau[r_slot[VW-1:0]] <= 1'b1;
                        if (r_cmd == CMD_RESUME) r_pau[r_slot[VW-1:0]] <= 1'b0;
                    end
                end
                S_TRD: begin
                    r_rdvld <= r_vld[r_idx];
                    r_play  <= 1'b0;
                    r_state <= S_TMIX;
                end
                S_TMIX: begin
                    // drop a finished one-shot, latch gains, write back position
                    if (ram_we) r_vld[r_idx] <= 1'b1;
                    if (r_act[r_idx] && !r_pau[r_idx] && endreg && !r_loop[r_idx])
                        r_act[r_idx] <= 1'b0;
                    r_gr   <= 17'((n_gr1 + 32'd16384) >> 15);
                    r_gl   <= 17'((n_gl1 + 32'd16384) >> 15);
                    r_play <= mix_on;
                    r_last <= (32'(r_idx) == VOICES - 1);
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    // scale by master, hold the sample word for the accumulate
                    r_gl2   <= 17'((gl_m + 34'd16384) >> 15);
                    r_gr2   <= 17'((gr_m + 34'd16384) >> 15);
                    r_sw2   <= r_sword;
                    r_play2 <= r_play;
                    r_state <= S_TACC;
                end
                S_TACC: begin
                    if (r_play2) begin
                        r_accl <= r_accl + 48'($signed(r_sw2[15:0])) *
                                  $signed({1'b0, r_gl2});
                        r_accr <= r_accr + 48'($signed(r_sw2[31:16])) *
                                  $signed({1'b0, r_gr2});
                    end
                    if (r_last) r_state <= S_OUT;
                    else begin
                        r_idx   <= r_idx + VW'(1);
                        r_state <= S_TRD;
                    end
                end
                S_OUT: begin
                    if (r_cmd == CMD_TICK) begin
                        r_lout <= rsat(r_accl);
                        r_rout <= rsat(r_accr);
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid             = r_ovalid;
    assign o_status            = r_status;
    assign o_handle_slot       = r_hslot;
    assign o_handle_generation = r_hgen;
    assign o_left_out          = r_lout;
    assign o_right_out         = r_rout;
    assign o_voice_active      = r_qact;
    assign o_voice_paused      = r_qpau;
    assign o_voice_position    = r_qpos;
endmodule

// ===== sv/mvsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_checker: port-level checks
// Handshake and result-field sanity seen at the top-level ports.
// ----------------------------------------------------------------------------
module mvsm_checker
    import mvsm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_left_out,
    input logic        o_voice_active
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)) else $error("beat dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_left_out == 16'd0 && !o_voice_active)
        else $error("pool full with data");
endmodule

bind multi_voice_sample_mixer mvsm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_status(o_status), .o_left_out(o_left_out),
    .o_voice_active(o_voice_active)
);
